@@ hdl/tick_ratio_reducer_assert.svh @@
// ----------------------------------------------------------------------------
// Tick ratio reducer assertion macros
// Concurrent assertion helpers shared by the reducer RTL files.
// ----------------------------------------------------------------------------
`ifndef TICK_RATIO_REDUCER_ASSERT_SVH
`define TICK_RATIO_REDUCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TRR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick_ratio_reducer: assertion failed");

// next-cycle implication
`define TRR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick_ratio_reducer: assertion failed");

`else

`define TRR_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TRR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/trr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick ratio reducer package
// Widths, unit constants, sequencer states and divider control types.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int RATE_W   = 31;
    localparam int LIMIT_W  = 64;
    localparam int DIVR_W   = 31;
    localparam int CNT_W    = 7;

    localparam logic [CNT_W-1:0] DIV_WIDE_STEPS   = 7'd64;
    localparam logic [CNT_W-1:0] DIV_NARROW_STEPS = 7'd32;

    localparam logic [4:0] MASK_LAST = 5'd30;

    localparam logic [1:0] UNIT_NS = 2'd0;
    localparam logic [1:0] UNIT_US = 2'd1;
    localparam logic [1:0] UNIT_MS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MASK,
        ST_GCD,
        ST_GCD_WAIT,
        ST_NUM,
        ST_DEN,
        ST_LIM,
        ST_DONE
    } trr_state_t;

    typedef struct packed {
        logic go;
        logic wide;
    } trr_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trr_div_stat_t;

    function automatic logic [29:0] unit_value(input logic [1:0] idx);
        logic [29:0] v;
        case (idx)
            UNIT_NS: v = 30'd1000000000;
            UNIT_US: v = 30'd1000000;
            default: v = 30'd1000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/trr_div.sv @@
`timescale 1ns / 1ps
`include "tick_ratio_reducer_assert.svh"
// ----------------------------------------------------------------------------
// Tick ratio reducer divider
// Radix-2 restoring divider, one quotient bit per cycle, 32 or 64 steps.
// ----------------------------------------------------------------------------
module trr_div import trr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  trr_div_ctl_t        ctl,
    input  logic [LIMIT_W-1:0]  dividend,
    input  logic [DIVR_W-1:0]   divisor,
    output trr_div_stat_t       stat,
    output logic [LIMIT_W-1:0]  quotient,
    output logic [DIVR_W-1:0]   remainder
);

    logic [LIMIT_W-1:0] quo_reg,  quo_next;
    logic [DIVR_W-1:0]  rem_reg,  rem_next;
    logic [DIVR_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               run_reg,  run_next;
    logic               done_reg, done_next;

    logic [DIVR_W:0]    partial;
    logic [DIVR_W:0]    diff;
    logic               ge;

    // divisor of zero gives an all-ones quotient in wide mode
    assign partial = {rem_reg, quo_reg[LIMIT_W-1]};
    assign ge      = (partial >= {1'b0, dvs_reg});
    assign diff    = partial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.go)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = ctl.wide ? DIV_WIDE_STEPS : DIV_NARROW_STEPS;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[LIMIT_W-2:0], ge};
            rem_next = ge ? diff[DIVR_W-1:0] : partial[DIVR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `TRR_ASSERT_IMPL(a_div_no_relaunch, clk, rst_n, ctl.go, !run_reg)
    `TRR_ASSERT_NEXT(a_div_go_runs, clk, rst_n, ctl.go, run_reg && !done_reg)
    `TRR_ASSERT_IMPL(a_div_done_idle, clk, rst_n, done_reg, !run_reg)

endmodule

@@ hdl/tick_ratio_reducer.sv @@
`timescale 1ns / 1ps
`include "tick_ratio_reducer_assert.svh"
// ----------------------------------------------------------------------------
// Tick ratio reducer
// Derives a rate mask and reduced ns/us/ms fractions with overflow limits.
//
//   channel   handshake         payload
//   input     start / busy      tick_rate
//   result    done (strobe)     rate_mask, {ns,us,ms}_{numerator,denominator,limit}
//
// One transaction at a time; busy stays high from acceptance until done.
// Steps: the mask, then per unit the Euclid, numerator, denominator and limit
// divisions on the shared bit-serial divider, then the result strobe.
// Reset clears the sequencer and divider control; results are not reset.
// The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module tick_ratio_reducer import trr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [RATE_W-1:0]   tick_rate,
    output logic                done,
    output logic [RATE_W-1:0]   rate_mask,
    output logic [30:0]         ns_numerator,
    output logic [29:0]         ns_denominator,
    output logic [LIMIT_W-1:0]  ns_limit,
    output logic [30:0]         us_numerator,
    output logic [19:0]         us_denominator,
    output logic [LIMIT_W-1:0]  us_limit,
    output logic [30:0]         ms_numerator,
    output logic [9:0]          ms_denominator,
    output logic [LIMIT_W-1:0]  ms_limit
);

    trr_state_t         state_reg, state_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [RATE_W-1:0]  sh_reg, sh_next;
    logic               seen_reg, seen_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [1:0]         unit_reg, unit_next;
    logic [30:0]        x_reg, x_next;
    logic [30:0]        y_reg, y_next;
    logic [30:0]        g_reg, g_next;
    logic [30:0]        num_reg, num_next;

    logic [RATE_W-1:0]  mask_reg, mask_next;
    logic [30:0]        ns_num_reg, ns_num_next;
    logic [29:0]        ns_den_reg, ns_den_next;
    logic [LIMIT_W-1:0] ns_lim_reg, ns_lim_next;
    logic [30:0]        us_num_reg, us_num_next;
    logic [19:0]        us_den_reg, us_den_next;
    logic [LIMIT_W-1:0] us_lim_reg, us_lim_next;
    logic [30:0]        ms_num_reg, ms_num_next;
    logic [9:0]         ms_den_reg, ms_den_next;
    logic [LIMIT_W-1:0] ms_lim_reg, ms_lim_next;

    trr_div_ctl_t       div_ctl;
    trr_div_stat_t      div_stat;
    logic [LIMIT_W-1:0] div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic [LIMIT_W-1:0] div_quo;
    logic [DIVR_W-1:0]  div_rem;

    logic [RATE_W-1:0]  rate_dec;
    logic [29:0]        unit_cur;

    assign rate_dec = tick_rate - 31'd1;
    assign unit_cur = unit_value(unit_reg);

    always_comb
    begin
        state_next   = state_reg;
        rate_next    = rate_reg;
        sh_next      = sh_reg;
        seen_next    = seen_reg;
        cnt_next     = cnt_reg;
        unit_next    = unit_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        g_next       = g_reg;
        num_next     = num_reg;
        mask_next    = mask_reg;
        ns_num_next  = ns_num_reg;
        ns_den_next  = ns_den_reg;
        ns_lim_next  = ns_lim_reg;
        us_num_next  = us_num_reg;
        us_den_next  = us_den_reg;
        us_lim_next  = us_lim_reg;
        ms_num_next  = ms_num_reg;
        ms_den_next  = ms_den_reg;
        ms_lim_next  = ms_lim_reg;
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rate_next  = tick_rate;
                    sh_next    = (tick_rate == '0) ? '0 : rate_dec;
                    seen_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_MASK;
                end
            end
            ST_MASK:
            begin
                // smear from the top bit of rate-1 downward
                seen_next = seen_reg | sh_reg[RATE_W-1];
                mask_next = {mask_reg[RATE_W-2:0], seen_reg | sh_reg[RATE_W-1]};
                sh_next   = {sh_reg[RATE_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MASK_LAST)
                begin
                    unit_next  = UNIT_NS;
                    x_next     = rate_reg;
                    y_next     = {1'b0, unit_value(UNIT_NS)};
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                div_ctl.go = 1'b1;
                if (y_reg == '0)
                begin
                    g_next       = x_reg;
                    div_dividend = {1'b0, rate_reg, 32'b0};
                    div_divisor  = x_reg;
                    state_next   = ST_NUM;
                end
                else
                begin
                    div_dividend = {1'b0, x_reg, 32'b0};
                    div_divisor  = y_reg;
                    state_next   = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    x_next     = y_reg;
                    y_next     = div_rem;
                    state_next = ST_GCD;
                end
            end
            ST_NUM:
            begin
                if (div_stat.done)
                begin
                    num_next     = div_quo[30:0];
                    div_ctl.go   = 1'b1;
                    div_dividend = {2'b0, unit_cur, 32'b0};
                    div_divisor  = g_reg;
                    state_next   = ST_DEN;
                end
            end
            ST_DEN:
            begin
                if (div_stat.done)
                begin
                    case (unit_reg)
                        UNIT_NS:
                        begin
                            ns_num_next = num_reg;
                            ns_den_next = div_quo[29:0];
                        end
                        UNIT_US:
                        begin
                            us_num_next = num_reg;
                            us_den_next = div_quo[19:0];
                        end
                        default:
                        begin
                            ms_num_next = num_reg;
                            ms_den_next = div_quo[9:0];
                        end
                    endcase
                    // a zero numerator yields all ones, matching the saturation
                    div_ctl.go   = 1'b1;
                    div_ctl.wide = 1'b1;
                    div_dividend = '1;
                    div_divisor  = num_reg;
                    state_next   = ST_LIM;
                end
            end
            ST_LIM:
            begin
                if (div_stat.done)
                begin
                    case (unit_reg)
                        UNIT_NS: ns_lim_next = div_quo;
                        UNIT_US: us_lim_next = div_quo;
                        default: ms_lim_next = div_quo;
                    endcase
                    if (unit_reg == UNIT_MS)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        unit_next  = unit_reg + 1'b1;
                        x_next     = rate_reg;
                        y_next     = {1'b0, unit_value(unit_reg + 1'b1)};
                        state_next = ST_GCD;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg   <= rate_next;
        sh_reg     <= sh_next;
        seen_reg   <= seen_next;
        cnt_reg    <= cnt_next;
        unit_reg   <= unit_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        g_reg      <= g_next;
        num_reg    <= num_next;
        mask_reg   <= mask_next;
        ns_num_reg <= ns_num_next;
        ns_den_reg <= ns_den_next;
        ns_lim_reg <= ns_lim_next;
        us_num_reg <= us_num_next;
        us_den_reg <= us_den_next;
        us_lim_reg <= us_lim_next;
        ms_num_reg <= ms_num_next;
        ms_den_reg <= ms_den_next;
        ms_lim_reg <= ms_lim_next;
    end

    trr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign rate_mask      = mask_reg;
    assign ns_numerator   = ns_num_reg;
    assign ns_denominator = ns_den_reg;
    assign ns_limit       = ns_lim_reg;
    assign us_numerator   = us_num_reg;
    assign us_denominator = us_den_reg;
    assign us_limit       = us_lim_reg;
    assign ms_numerator   = ms_num_reg;
    assign ms_denominator = ms_den_reg;
    assign ms_limit       = ms_lim_reg;

    `TRR_ASSERT_NEXT(a_start_goes_busy, clk, rst_n, start && !busy, state_reg == ST_MASK)
    `TRR_ASSERT_NEXT(a_done_releases, clk, rst_n, done, !busy)
    `TRR_ASSERT_IMPL(a_go_when_free, clk, rst_n, div_ctl.go, !div_stat.busy)
    `TRR_ASSERT_IMPL(a_div_done_expected, clk, rst_n, div_stat.done,
        state_reg == ST_GCD_WAIT || state_reg == ST_NUM ||
        state_reg == ST_DEN || state_reg == ST_LIM)

endmodule

@@ sim/tick_ratio_reducer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick ratio reducer testbench
// Drives tick rates through start/busy and checks each done strobe against an
// in-bench model: power-of-two mask, gcd-reduced ns/us/ms fractions and
// 64-bit overflow limits. A short table of edge rates runs first. Rates of
// one, zero, two and the maximum have typed-in results; every other rate is
// checked against the model. Random rates with random gaps follow.
// ----------------------------------------------------------------------------
module tick_ratio_reducer_test;
    import trr_pkg::*;

    localparam logic [63:0] NS_PER_S = 64'd1000000000;
    localparam logic [63:0] US_PER_S = 64'd1000000;
    localparam logic [63:0] MS_PER_S = 64'd1000;
    localparam logic [63:0] LIM_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_ITEMS = 300;
    localparam int          DIRECTED_ITEMS = 20;

    typedef struct packed {
        logic [RATE_W-1:0]  mask;
        logic [30:0]        ns_num;
        logic [29:0]        ns_den;
        logic [LIMIT_W-1:0] ns_lim;
        logic [30:0]        us_num;
        logic [19:0]        us_den;
        logic [LIMIT_W-1:0] us_lim;
        logic [30:0]        ms_num;
        logic [9:0]         ms_den;
        logic [LIMIT_W-1:0] ms_lim;
    } tick_result_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              typed;
        tick_result_t      fixed;
    } rate_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [RATE_W-1:0]   tick_rate;
    logic                done;
    logic [RATE_W-1:0]   rate_mask;
    logic [30:0]         ns_numerator;
    logic [29:0]         ns_denominator;
    logic [LIMIT_W-1:0]  ns_limit;
    logic [30:0]         us_numerator;
    logic [19:0]         us_denominator;
    logic [LIMIT_W-1:0]  us_limit;
    logic [30:0]         ms_numerator;
    logic [9:0]          ms_denominator;
    logic [LIMIT_W-1:0]  ms_limit;

    tick_result_t pending_results[$];
    int           err_count = 0;

    rate_row_t edge_rates[DIRECTED_ITEMS] = '{
        '{31'd1, 1'b1, '{31'd0, 31'd1, 30'd1000000000, LIM_MAX,
                         31'd1, 20'd1000000, LIM_MAX, 31'd1, 10'd1000, LIM_MAX}},
        '{31'd0, 1'b1, '{31'd0, 31'd0, 30'd1, LIM_MAX,
                         31'd0, 20'd1, LIM_MAX, 31'd0, 10'd1, LIM_MAX}},
        '{31'd2, 1'b1, '{31'd1, 31'd1, 30'd500000000, LIM_MAX,
                         31'd1, 20'd500000, LIM_MAX, 31'd1, 10'd500, LIM_MAX}},
        '{31'h7FFFFFFF, 1'b1, '{31'h7FFFFFFF, 31'h7FFFFFFF, 30'd1000000000,
                                64'd8589934596, 31'h7FFFFFFF, 20'd1000000,
                                64'd8589934596, 31'h7FFFFFFF, 10'd1000,
                                64'd8589934596}},
        '{31'd3,          1'b0, '0},
        '{31'd1000,       1'b0, '0},
        '{31'd1000000,    1'b0, '0},
        '{31'd1000000000, 1'b0, '0},
        '{31'd2000000000, 1'b0, '0},
        '{31'd1073741824, 1'b0, '0},
        '{31'd1073741825, 1'b0, '0},
        '{31'd1073741823, 1'b0, '0},
        '{31'd1836311903, 1'b0, '0},
        '{31'd1953125,    1'b0, '0},
        '{31'd48000,      1'b0, '0},
        '{31'd32768,      1'b0, '0},
        '{31'd100,        1'b0, '0},
        '{31'd999999999,  1'b0, '0},
        '{31'd1000000007, 1'b0, '0},
        '{31'h55555555,   1'b0, '0}
    };

    tick_ratio_reducer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .tick_rate      (tick_rate),
        .done           (done),
        .rate_mask      (rate_mask),
        .ns_numerator   (ns_numerator),
        .ns_denominator (ns_denominator),
        .ns_limit       (ns_limit),
        .us_numerator   (us_numerator),
        .us_denominator (us_denominator),
        .us_limit       (us_limit),
        .ms_numerator   (ms_numerator),
        .ms_denominator (ms_denominator),
        .ms_limit       (ms_limit)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic tick_result_t predict_ratios(input logic [RATE_W-1:0] rate);
        tick_result_t res;
        logic [63:0]  r64;
        logic [63:0]  m;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  t;
        logic [63:0]  units[3];
        logic [63:0]  num[3];
        logic [63:0]  den[3];
        logic [63:0]  lim[3];
        r64 = {33'd0, rate};
        units[0] = NS_PER_S;
        units[1] = US_PER_S;
        units[2] = MS_PER_S;
        m = 64'd1;
        while (m < r64)
            m = m << 1;
        m = m - 64'd1;
        for (int u = 0; u < 3; u++)
        begin
            a = r64;
            b = units[u];
            while (b != 64'd0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            num[u] = r64 / a;
            den[u] = units[u] / a;
            lim[u] = (num[u] == 64'd0) ? LIM_MAX : LIM_MAX / num[u];
        end
        res.mask   = m[RATE_W-1:0];
        res.ns_num = num[0][30:0];
        res.ns_den = den[0][29:0];
        res.ns_lim = lim[0];
        res.us_num = num[1][30:0];
        res.us_den = den[1][19:0];
        res.us_lim = lim[1];
        res.ms_num = num[2][30:0];
        res.ms_den = den[2][9:0];
        res.ms_lim = lim[2];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
                     exp_val, act_val);
            err_count++;
        end
    endtask

    // results are sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        tick_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got mask %0d",
                         $time, rate_mask);
                err_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("rate_mask",      exp_res.mask,   rate_mask);
                check_field("ns_numerator",   exp_res.ns_num, ns_numerator);
                check_field("ns_denominator", exp_res.ns_den, ns_denominator);
                check_field("ns_limit",       exp_res.ns_lim, ns_limit);
                check_field("us_numerator",   exp_res.us_num, us_numerator);
                check_field("us_denominator", exp_res.us_den, us_denominator);
                check_field("us_limit",       exp_res.us_lim, us_limit);
                check_field("ms_numerator",   exp_res.ms_num, ms_numerator);
                check_field("ms_denominator", exp_res.ms_den, ms_denominator);
                check_field("ms_limit",       exp_res.ms_lim, ms_limit);
            end
        end
    end

    task automatic send_rate(input logic [RATE_W-1:0] rate, input logic typed,
                             input tick_result_t fixed);
        @(negedge clk);
        start     <= 1'b1;
        tick_rate <= rate;
        do
            @(posedge clk);
        while (busy);
        if (typed)
            pending_results.push_back(fixed);
        else
            pending_results.push_back(predict_ratios(rate));
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [63:0] r64;
        int          burst_left;
        int          kind;
        int          gap;
        rst_n     = 1'b0;
        start     = 1'b0;
        tick_rate = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (edge_rates[i])
        begin
            send_rate(edge_rates[i].rate, edge_rates[i].typed, edge_rates[i].fixed);
            idle_gap((i % 3 == 0) ? 0 : $urandom_range(0, 10));
        end
        idle_gap(1);
        while (pending_results.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: r64 = {32'd0, $urandom()};
                1: r64 = $urandom_range(1, 100000);
                2:
                begin
                    // rates built from factors of two and five, times a multiplier of 1 to 50, reduce far
                    r64 = 64'd1 << $urandom_range(0, 12);
                    repeat ($urandom_range(0, 9)) r64 = r64 * 64'd5;
                    r64 = r64 * $urandom_range(1, 50);
                end
                default: r64 = (64'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 64'd1;
            endcase
            send_rate(r64[RATE_W-1:0], 1'b0, '0);

            if (n == RANDOM_ITEMS / 2)
            begin
                idle_gap(1);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            if (burst_left == 0 && $urandom_range(0, 15) == 0)
                burst_left = $urandom_range(5, 20);
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
                gap = $urandom_range(0, 10);
            idle_gap(gap);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
